// ===== rtl/mrpmr_pkg.sv =====
// Package for the multi-reader priority message ring.
// Holds ring sizes, field widths, mode, type and status codes and the FSM state type.
// Depends on nothing.
`default_nettype none
package mrpmr_pkg;

  localparam int unsigned RING_DEPTH    = 2048;
  localparam int unsigned BASE_CAPACITY = 1024;
  localparam int unsigned READER_COUNT  = 16;

  localparam int unsigned PTR_W = 11;   // ring position
  localparam int unsigned CAP_W = 12;   // working capacity, up to RING_DEPTH
  localparam int unsigned HDR_W = 18;   // type, source, target
  localparam int unsigned ENT_W = HDR_W + 32 + 32 + 32;

  localparam logic [7:0] BROADCAST_ID = 8'hFF;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_COMPACT = 2'd2,
    MODE_STATUS  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    MSG_ORDINARY = 2'd0,
    MSG_ALERT    = 2'd1,
    MSG_NOTICE   = 2'd2,
    MSG_OTHER    = 2'd3
  } msg_type_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_FILTERED  = 2'd2,
    STS_DELIVERED = 2'd3
  } status_e;

  typedef enum logic {
    REG_PROTECTED = 1'b0,
    REG_SENSORY   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CHECK,
    ST_RD_DATA,
    ST_RD_SUM,
    ST_CMP_LOAD,
    ST_DIV,
    ST_CMP_DONE,
    ST_STAT_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/multi_reader_priority_message_ring_top.sv =====
// Top level of the multi-reader priority message ring: ring memory, head registers, control FSM.
// Depends on mrpmr_pkg.
`default_nettype none
// Broadcast message ring with one write pointer, one oldest pointer and READER_COUNT read
// heads. Messages live in one synchronous 2048-entry memory with a registered read port.
// A push gives one result. A read walks the ring from the reader's head: each ring entry
// visited takes a memory read, then a test and delivery, and a summary item follows.
// Distances modulo the working capacity come from a shared one-bit-per-cycle remainder
// unit, used by status and by compact. One request is worked at a time; no clearing
// pass after reset.
module multi_reader_priority_message_ring_top #(
  parameter int unsigned READER_COUNT = mrpmr_pkg::READER_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [1:0]  msg_type_i,
  input  wire logic [7:0]  msg_source_i,
  input  wire logic [7:0]  msg_target_i,
  input  wire logic [31:0] msg_address_i,
  input  wire logic [31:0] msg_length_i,
  input  wire logic [7:0]  reader_id_i,
  input  wire logic [5:0]  max_count_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [1:0]       out_type_o,
  output logic [7:0]       out_source_o,
  output logic [7:0]       out_target_o,
  output logic [31:0]      out_address_o,
  output logic [31:0]      out_length_o,
  output logic [31:0]      out_sequence_o,
  output logic             last_o,
  output logic [31:0]      drop_total_o,
  output logic [31:0]      push_total_o,
  output logic [10:0]      tally_o,
  output logic [11:0]      capacity_now_o
);

  localparam int unsigned PTR_W  = mrpmr_pkg::PTR_W;
  localparam int unsigned CAP_W  = mrpmr_pkg::CAP_W;
  localparam int unsigned HDR_W  = mrpmr_pkg::HDR_W;
  localparam int unsigned ENT_W  = mrpmr_pkg::ENT_W;
  localparam int unsigned DEPTH  = mrpmr_pkg::RING_DEPTH;
  localparam int unsigned HEAD_W = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
  localparam int unsigned CIDX_W = $clog2(READER_COUNT + 1);

  // ---------------------------------------------------------------- registers
  mrpmr_pkg::state_e state_q, state_d;

  logic [7:0]       prot_q, sens_q;
  logic [PTR_W-1:0] wp_q, wp_d, old_q, old_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [31:0]      seq_q, seq_d, drop_q, drop_d, push_q, push_d;
  logic [PTR_W-1:0] heads_q [READER_COUNT];

  logic [HEAD_W-1:0] reader_q, reader_d;
  logic              rd_ok_q, rd_ok_d;
  logic [5:0]        limit_q, limit_d, got_q, got_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CAP_W-1:0]  steps_q, steps_d;

  logic              op_cmp_q, op_cmp_d;
  logic [PTR_W-1:0]  best_q, best_d, cur_q, cur_d;
  logic [CAP_W-1:0]  best_dist_q, best_dist_d, dist_q, dist_d;
  logic [CIDX_W-1:0] cidx_q, cidx_d;

  logic [31:0]      num_q, num_d;
  logic [CAP_W-1:0] rem_q, rem_d;
  logic [4:0]       dcnt_q, dcnt_d;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_q;

  logic        out_valid_q;
  logic [1:0]  o_status_q, o_status_d, o_type_q, o_type_d;
  logic [7:0]  o_src_q, o_src_d, o_tgt_q, o_tgt_d;
  logic [31:0] o_addr_q, o_addr_d, o_len_q, o_len_d, o_seq_q, o_seq_d;
  logic        o_last_q, o_last_d;
  logic [31:0] o_drop_q, o_drop_d, o_push_q, o_push_d;
  logic [10:0] o_tally_q, o_tally_d;
  logic [11:0] o_cap_q, o_cap_d;

  // ---------------------------------------------------------------- shared terms
  logic              in_acc, out_free, out_load;
  logic              mem_we, mem_re, drag, head_wb;
  logic [ENT_W-1:0]  mem_wdata;
  logic [PTR_W-1:0]  old_new;
  logic [HEAD_W-1:0] head_idx;
  logic [PTR_W-1:0]  head_rd;
  logic              rd_go, rd_match, div_last;
  logic [CAP_W:0]    div_t;
  logic [CAP_W-1:0]  div_r;
  logic [CAP_W-1:0]  wp_inc, old_inc, head_inc;
  logic [PTR_W-1:0]  wp_nxt, old_nxt, head_nxt;
  logic [7:0]        rd_tgt;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == mrpmr_pkg::ST_IDLE && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // position + 1 modulo capacity; position stays below twice the capacity
  assign wp_inc   = CAP_W'(wp_q) + CAP_W'(1);
  assign wp_nxt   = (wp_inc >= cap_q) ? PTR_W'(wp_inc - cap_q) : PTR_W'(wp_inc);
  assign old_inc  = CAP_W'(old_q) + CAP_W'(1);
  assign old_nxt  = (old_inc >= cap_q) ? PTR_W'(old_inc - cap_q) : PTR_W'(old_inc);
  assign head_inc = CAP_W'(head_q) + CAP_W'(1);
  assign head_nxt = (head_inc >= cap_q) ? PTR_W'(head_inc - cap_q) : PTR_W'(head_inc);

  // single head read port: reader id on entry, sweep index during compact
  assign head_idx = (state_q == mrpmr_pkg::ST_IDLE) ? reader_id_i[HEAD_W-1:0]
                                                    : cidx_q[HEAD_W-1:0];
  assign head_rd  = heads_q[head_idx];

  assign rd_go = (head_q != wp_q) && (got_q < limit_q) && (steps_q <= cap_q);
  assign rd_tgt   = rdata_q[ENT_W-HDR_W+7 -: 8];
  assign rd_match = (rd_tgt == mrpmr_pkg::BROADCAST_ID) || (rd_tgt == 8'(reader_q));

  // one restoring remainder step
  assign div_t    = {rem_q, num_q[31]};
  assign div_r    = (div_t >= {1'b0, cap_q}) ? CAP_W'(div_t - {1'b0, cap_q})
                                             : CAP_W'(div_t);
  assign div_last = (dcnt_q == 5'd31);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mrpmr_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (mrpmr_pkg::mode_e'(mode_i))
            mrpmr_pkg::MODE_READ: begin
              state_d = (reader_id_i < 8'(READER_COUNT)) ? mrpmr_pkg::ST_RD_CHECK
                                                         : mrpmr_pkg::ST_RD_SUM;
            end
            mrpmr_pkg::MODE_COMPACT: state_d = mrpmr_pkg::ST_CMP_LOAD;
            mrpmr_pkg::MODE_STATUS:  state_d = mrpmr_pkg::ST_DIV;
            default:                 state_d = mrpmr_pkg::ST_IDLE;
          endcase
        end
      end
      mrpmr_pkg::ST_RD_CHECK: begin
        state_d = rd_go ? mrpmr_pkg::ST_RD_DATA : mrpmr_pkg::ST_RD_SUM;
      end
      mrpmr_pkg::ST_RD_DATA: begin
        if (!rd_match || out_free) state_d = mrpmr_pkg::ST_RD_CHECK;
      end
      mrpmr_pkg::ST_RD_SUM: begin
        if (out_free) state_d = mrpmr_pkg::ST_IDLE;
      end
      mrpmr_pkg::ST_CMP_LOAD: begin
        state_d = (cidx_q == CIDX_W'(READER_COUNT)) ? mrpmr_pkg::ST_CMP_DONE
                                                    : mrpmr_pkg::ST_DIV;
      end
      mrpmr_pkg::ST_DIV: begin
        if (div_last) state_d = op_cmp_q ? mrpmr_pkg::ST_CMP_LOAD : mrpmr_pkg::ST_STAT_DONE;
      end
      mrpmr_pkg::ST_CMP_DONE, mrpmr_pkg::ST_STAT_DONE: begin
        if (out_free) state_d = mrpmr_pkg::ST_IDLE;
      end
      default: state_d = mrpmr_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    wp_d = wp_q;  old_d = old_q;  cap_d = cap_q;
    seq_d = seq_q;  drop_d = drop_q;  push_d = push_q;
    reader_d = reader_q;  rd_ok_d = rd_ok_q;  limit_d = limit_q;  got_d = got_q;
    head_d = head_q;  steps_d = steps_q;
    op_cmp_d = op_cmp_q;  best_d = best_q;  cur_d = cur_q;
    best_dist_d = best_dist_q;  dist_d = dist_q;  cidx_d = cidx_q;
    num_d = num_q;  rem_d = rem_q;  dcnt_d = dcnt_q;
    mem_we = 1'b0;  mem_re = 1'b0;  drag = 1'b0;  head_wb = 1'b0;
    old_new = old_nxt;
    mem_wdata = {msg_type_i, msg_source_i, msg_target_i, msg_address_i, msg_length_i, seq_q};
    out_load = 1'b0;
    o_status_d = mrpmr_pkg::STS_DONE;  o_type_d = '0;  o_src_d = '0;  o_tgt_d = '0;
    o_addr_d = '0;  o_len_d = '0;  o_seq_d = '0;  o_last_d = 1'b1;
    o_drop_d = '0;  o_push_d = '0;  o_tally_d = '0;  o_cap_d = '0;

    case (state_q)
      mrpmr_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (mrpmr_pkg::mode_e'(mode_i))
            mrpmr_pkg::MODE_PUSH: begin
              // full ring: drop unless alert or notice, else evict before the filter; then store
              push_d   = push_q + 32'd1;
              out_load = 1'b1;
              if (wp_nxt == old_q &&
                  !(msg_type_i == mrpmr_pkg::MSG_ALERT ||
                    msg_type_i == mrpmr_pkg::MSG_NOTICE)) begin
                drop_d     = drop_q + 32'd1;
                o_status_d = mrpmr_pkg::STS_FULL;
              end else begin
                if (wp_nxt == old_q) begin
                  old_d = old_nxt;
                  drag  = 1'b1;
                end
                if (msg_target_i == prot_q && msg_type_i == mrpmr_pkg::MSG_ORDINARY &&
                    msg_source_i != sens_q) begin
                  drop_d     = drop_q + 32'd1;
                  o_status_d = mrpmr_pkg::STS_FILTERED;
                end else begin
                  if (msg_type_i == mrpmr_pkg::MSG_ALERT) begin
                    cap_d = CAP_W'(mrpmr_pkg::RING_DEPTH);
                  end else if (cap_q > CAP_W'(mrpmr_pkg::BASE_CAPACITY)) begin
                    cap_d = cap_q - CAP_W'(1);
                  end
                  mem_we = 1'b1;
                  seq_d  = seq_q + 32'd1;
                  wp_d   = wp_nxt;
                end
              end
            end
            mrpmr_pkg::MODE_READ: begin
              reader_d = reader_id_i[HEAD_W-1:0];
              rd_ok_d  = (reader_id_i < 8'(READER_COUNT));
              limit_d  = max_count_i;
              head_d   = head_rd;
              steps_d  = '0;
              got_d    = '0;
            end
            mrpmr_pkg::MODE_COMPACT: begin
              op_cmp_d    = 1'b1;
              best_d      = wp_q;
              best_dist_d = '0;
              cidx_d      = '0;
            end
            mrpmr_pkg::MODE_STATUS: begin
              op_cmp_d = 1'b0;
              num_d    = 32'(wp_q) - 32'(old_q) + 32'(cap_q);
              rem_d    = '0;
              dcnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      mrpmr_pkg::ST_RD_CHECK: begin
        if (rd_go) mem_re = 1'b1;
        else       head_wb = rd_ok_q;
      end
      mrpmr_pkg::ST_RD_DATA: begin
        // deliver on match, then advance the head
        if (!rd_match || out_free) begin
          if (rd_match) begin
            out_load   = 1'b1;
            o_status_d = mrpmr_pkg::STS_DELIVERED;
            o_type_d   = rdata_q[ENT_W-1 -: 2];
            o_src_d    = rdata_q[ENT_W-3 -: 8];
            o_tgt_d    = rd_tgt;
            o_addr_d   = rdata_q[95:64];
            o_len_d    = rdata_q[63:32];
            o_seq_d    = rdata_q[31:0];
            o_last_d   = 1'b0;
            got_d      = got_q + 6'd1;
          end
          head_d  = head_nxt;
          steps_d = steps_q + CAP_W'(1);
        end
      end
      mrpmr_pkg::ST_RD_SUM: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_tally_d = 11'(got_q);
        end
      end
      mrpmr_pkg::ST_CMP_LOAD: begin
        if (cidx_q != CIDX_W'(READER_COUNT)) begin
          cur_d  = head_rd;
          num_d  = 32'(wp_q) - 32'(head_rd) + 32'(cap_q);
          rem_d  = '0;
          dcnt_d = '0;
        end
      end
      mrpmr_pkg::ST_DIV: begin
        rem_d  = div_r;
        num_d  = {num_q[30:0], 1'b0};
        dcnt_d = dcnt_q + 5'd1;
        if (div_last) begin
          dist_d = div_r;
          if (op_cmp_q) begin
            if (div_r > best_dist_q) begin
              best_d      = cur_q;
              best_dist_d = div_r;
            end
            cidx_d = cidx_q + CIDX_W'(1);
          end
        end
      end
      mrpmr_pkg::ST_CMP_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          old_d    = best_q;
        end
      end
      mrpmr_pkg::ST_STAT_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_drop_d  = drop_q;
          o_push_d  = push_q;
          o_tally_d = 11'(dist_q);
          o_cap_d   = cap_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrpmr_pkg::ST_IDLE;
      prot_q      <= 8'd0;
      sens_q      <= 8'd1;
      wp_q        <= '0;
      old_q       <= '0;
      cap_q       <= CAP_W'(mrpmr_pkg::BASE_CAPACITY);
      seq_q       <= 32'd1;
      drop_q      <= '0;
      push_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < READER_COUNT; i++) heads_q[i] <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      old_q   <= old_d;
      cap_q   <= cap_d;
      seq_q   <= seq_d;
      drop_q  <= drop_d;
      push_q  <= push_d;
      // take configuration writes
      if (psel && penable && pwrite) begin
        if (mrpmr_pkg::reg_idx_e'(paddr[2]) == mrpmr_pkg::REG_PROTECTED) prot_q <= pwdata[7:0];
        else                                                              sens_q <= pwdata[7:0];
      end
      // move heads that sit at the write pointer to the new oldest entry on an eviction
      if (drag) begin
        for (int i = 0; i < READER_COUNT; i++) begin
          if (heads_q[i] == wp_q) heads_q[i] <= old_new;
        end
      end
      if (head_wb) heads_q[reader_q] <= head_q;
      if (out_load)      out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk_i) begin
    reader_q    <= reader_d;
    rd_ok_q     <= rd_ok_d;
    limit_q     <= limit_d;
    got_q       <= got_d;
    head_q      <= head_d;
    steps_q     <= steps_d;
    op_cmp_q    <= op_cmp_d;
    best_q      <= best_d;
    cur_q       <= cur_d;
    best_dist_q <= best_dist_d;
    dist_q      <= dist_d;
    cidx_q      <= cidx_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    dcnt_q      <= dcnt_d;
    if (out_load) begin
      o_status_q <= o_status_d;
      o_type_q   <= o_type_d;
      o_src_q    <= o_src_d;
      o_tgt_q    <= o_tgt_d;
      o_addr_q   <= o_addr_d;
      o_len_q    <= o_len_d;
      o_seq_q    <= o_seq_d;
      o_last_q   <= o_last_d;
      o_drop_q   <= o_drop_d;
      o_push_q   <= o_push_d;
      o_tally_q  <= o_tally_d;
      o_cap_q    <= o_cap_d;
    end
  end

  // ---------------------------------------------------------------- ring memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_q] <= mem_wdata;
    if (mem_re) rdata_q <= mem[head_q];
  end

  // ---------------------------------------------------------------- ports
  assign pready = 1'b1;
  assign prdata = (mrpmr_pkg::reg_idx_e'(paddr[2]) == mrpmr_pkg::REG_PROTECTED)
                  ? {24'd0, prot_q} : {24'd0, sens_q};

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_status_q;
  assign out_type_o     = o_type_q;
  assign out_source_o   = o_src_q;
  assign out_target_o   = o_tgt_q;
  assign out_address_o  = o_addr_q;
  assign out_length_o   = o_len_q;
  assign out_sequence_o = o_seq_q;
  assign last_o         = o_last_q;
  assign drop_total_o   = o_drop_q;
  assign push_total_o   = o_push_q;
  assign tally_o        = o_tally_q;
  assign capacity_now_o = o_cap_q;

`ifndef SYNTHESIS
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q >= CAP_W'(mrpmr_pkg::BASE_CAPACITY) && cap_q <= CAP_W'(mrpmr_pkg::RING_DEPTH))
    else $error("working capacity out of range");
  a_got_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrpmr_pkg::ST_RD_CHECK) |-> got_q <= limit_q)
    else $error("read delivered more than requested");
  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == mrpmr_pkg::MODE_PUSH) |=> (out_valid_o && last_o))
    else $error("push gave no final result");
  a_idle_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrpmr_pkg::ST_RD_SUM && out_free) |=> (out_valid_o && last_o &&
    state_q == mrpmr_pkg::ST_IDLE))
    else $error("read summary not delivered");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for multi_reader_priority_message_ring_top: random and directed requests
// with a bit-exact ring predictor in a scoreboard class. Depends on mrpmr_pkg and the top level.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned N_HEADS     = 16;

  typedef struct {
    mrpmr_pkg::mode_e     mode;
    mrpmr_pkg::msg_type_e mtype;
    logic [7:0]           src;
    logic [7:0]           tgt;
    logic [31:0]          addr;
    logic [31:0]          len;
    logic [7:0]           reader;
    logic [5:0]           maxc;
  } request_t;

  typedef struct {
    mrpmr_pkg::status_e status;
    logic [1:0]         mtype;
    logic [7:0]         src;
    logic [7:0]         tgt;
    logic [31:0]        addr;
    logic [31:0]        len;
    logic [31:0]        seq;
    logic               last;
    logic [31:0]        drops;
    logic [31:0]        pushes;
    logic [10:0]        tally;
    logic [11:0]        capacity;
  } result_t;

  // Predicts the ring's results and compares them with what comes out.
  class ring_scoreboard;
    logic [17:0] hdr_mem [mrpmr_pkg::RING_DEPTH];
    int unsigned addr_mem [mrpmr_pkg::RING_DEPTH];
    int unsigned len_mem [mrpmr_pkg::RING_DEPTH];
    int unsigned seq_mem [mrpmr_pkg::RING_DEPTH];
    bit          written [mrpmr_pkg::RING_DEPTH];
    int unsigned wr_ptr, oldest, cap, next_seq, drops, pushes, prot_id, sens_id;
    int unsigned heads [N_HEADS];
    result_t     expected_q [$];
    int          errors;

    function new();
      foreach (written[i]) written[i] = 0;
      foreach (heads[i]) heads[i] = 0;
      wr_ptr = 0; oldest = 0; cap = mrpmr_pkg::BASE_CAPACITY; next_seq = 1;
      drops = 0; pushes = 0; prot_id = 0; sens_id = 1; errors = 0;
    endfunction

    function int unsigned cap_nz();
      return (cap == 0) ? 1 : cap;
    endfunction

    function int unsigned dist_to_wr(int unsigned h, int unsigned c);
      int unsigned d;
      d = wr_ptr - h + c;
      return d % c;
    endfunction

    function void set_reg(mrpmr_pkg::reg_idx_e idx, logic [7:0] val);
      if (idx == mrpmr_pkg::REG_PROTECTED) prot_id = {24'd0, val};
      else sens_id = {24'd0, val};
    endfunction

    // True when a read for this reader would visit a slot never written.
    function bit read_hits_blank(logic [7:0] reader, logic [5:0] maxc);
      int unsigned h, steps, got, c;
      c = cap_nz(); steps = 0; got = 0;
      if (reader >= N_HEADS) return 0;
      h = heads[reader];
      while (h != wr_ptr && got < maxc && steps <= c) begin
        if (!written[h % mrpmr_pkg::RING_DEPTH]) return 1;
        if (hdr_mem[h % mrpmr_pkg::RING_DEPTH][7:0] == mrpmr_pkg::BROADCAST_ID ||
            hdr_mem[h % mrpmr_pkg::RING_DEPTH][7:0] == reader) got++;
        h = (h + 1) % c;
        steps++;
      end
      return 0;
    endfunction

    function void note_request(request_t r);
      result_t e;
      int unsigned c, nxt, slot, h, steps, got;
      e = '{status: mrpmr_pkg::STS_DONE, last: 1'b1, default: '0};
      c = cap_nz();
      case (r.mode)
        mrpmr_pkg::MODE_PUSH: begin
          pushes++;
          nxt = (wr_ptr + 1) % c;
          if (nxt == oldest) begin
            if (r.mtype == mrpmr_pkg::MSG_ALERT || r.mtype == mrpmr_pkg::MSG_NOTICE) begin
              // evict the oldest entry and move heads at the write pointer to the new oldest
              oldest = (oldest + 1) % c;
              foreach (heads[i]) if (heads[i] == wr_ptr) heads[i] = oldest;
            end else begin
              drops++;
              e.status = mrpmr_pkg::STS_FULL;
            end
          end
          if (e.status == mrpmr_pkg::STS_DONE && r.tgt == prot_id &&
              r.mtype == mrpmr_pkg::MSG_ORDINARY && r.src != sens_id) begin
            drops++;
            e.status = mrpmr_pkg::STS_FILTERED;
          end
          if (e.status == mrpmr_pkg::STS_DONE) begin
            if (r.mtype == mrpmr_pkg::MSG_ALERT) cap = mrpmr_pkg::RING_DEPTH;
            else if (cap > mrpmr_pkg::BASE_CAPACITY) cap--;
            slot = wr_ptr % mrpmr_pkg::RING_DEPTH;
            hdr_mem[slot] = {r.mtype, r.src, r.tgt};
            addr_mem[slot] = r.addr; len_mem[slot] = r.len;
            seq_mem[slot] = next_seq; written[slot] = 1;
            next_seq++;
            wr_ptr = nxt;
          end
          expected_q.push_back(e);
        end
        mrpmr_pkg::MODE_READ: begin
          got = 0;
          if (r.reader < N_HEADS) begin
            h = heads[r.reader]; steps = 0;
            while (h != wr_ptr && got < r.maxc && steps <= c) begin
              slot = h % mrpmr_pkg::RING_DEPTH;
              if (hdr_mem[slot][7:0] == mrpmr_pkg::BROADCAST_ID ||
                  hdr_mem[slot][7:0] == r.reader) begin
                e = '{status: mrpmr_pkg::STS_DELIVERED, default: '0};
                e.mtype = hdr_mem[slot][17:16]; e.src = hdr_mem[slot][15:8];
                e.tgt = hdr_mem[slot][7:0]; e.addr = addr_mem[slot];
                e.len = len_mem[slot]; e.seq = seq_mem[slot];
                expected_q.push_back(e);
                got++;
              end
              h = (h + 1) % c;
              steps++;
            end
            heads[r.reader] = h;
          end
          e = '{status: mrpmr_pkg::STS_DONE, last: 1'b1, default: '0};
          e.tally = got[10:0];
          expected_q.push_back(e);
        end
        mrpmr_pkg::MODE_COMPACT: begin
          nxt = wr_ptr;
          foreach (heads[i]) if (dist_to_wr(heads[i], c) > dist_to_wr(nxt, c)) nxt = heads[i];
          oldest = nxt;
          expected_q.push_back(e);
        end
        default: begin
          e.drops = drops; e.pushes = pushes;
          e.tally = 11'(dist_to_wr(oldest, c));
          e.capacity = cap[11:0];
          expected_q.push_back(e);
        end
      endcase
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result, status %0d", a.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("status", e.status, a.status);
      cmp("out_type", e.mtype, a.mtype);
      cmp("out_source", e.src, a.src);
      cmp("out_target", e.tgt, a.tgt);
      cmp("out_address", e.addr, a.addr);
      cmp("out_length", e.len, a.len);
      cmp("out_sequence", e.seq, a.seq);
      cmp("last", e.last, a.last);
      cmp("drop_total", e.drops, a.drops);
      cmp("push_total", e.pushes, a.pushes);
      cmp("tally", e.tally, a.tally);
      cmp("capacity_now", e.capacity, a.capacity);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0, msg_type_i = '0;
  logic [7:0]  msg_source_i = '0, msg_target_i = '0, reader_id_i = '0;
  logic [31:0] msg_address_i = '0, msg_length_i = '0;
  logic [5:0]  max_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o, out_type_o;
  logic [7:0]  out_source_o, out_target_o;
  logic [31:0] out_address_o, out_length_o, out_sequence_o, drop_total_o, push_total_o;
  logic        last_o;
  logic [10:0] tally_o;
  logic [11:0] capacity_now_o;

  ring_scoreboard sb = new();
  int unsigned send_idle_pct = 36, recv_idle_pct = 80;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  multi_reader_priority_message_ring_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receive results, check them, and stall at random or for a long hold-off.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result('{mrpmr_pkg::status_e'(status_o), out_type_o, out_source_o,
                        out_target_o, out_address_o, out_length_o, out_sequence_o, last_o,
                        drop_total_o, push_total_o, tally_o, capacity_now_o});
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("multi_reader_priority_message_ring_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(request_t r);
    // turn an unsafe read into a status query so no blank slot is visited
    if (r.mode == mrpmr_pkg::MODE_READ && sb.read_hits_blank(r.reader, r.maxc))
      r.mode = mrpmr_pkg::MODE_STATUS;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= r.mode;
    msg_type_i    <= r.mtype;
    msg_source_i  <= r.src;
    msg_target_i  <= r.tgt;
    msg_address_i <= r.addr;
    msg_length_i  <= r.len;
    reader_id_i   <= r.reader;
    max_count_i   <= r.maxc;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(mrpmr_pkg::reg_idx_e idx, logic [7:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(idx) << 2; pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic request_t mk(mrpmr_pkg::mode_e m, mrpmr_pkg::msg_type_e t,
                                  int unsigned s, int unsigned g,
                                  logic [31:0] a, logic [31:0] l, int unsigned rd,
                                  int unsigned mc);
    return '{m, t, 8'(s), 8'(g), a, l, 8'(rd), 6'(mc)};
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) r.mode = mrpmr_pkg::MODE_PUSH;
    else if (p < 80) r.mode = mrpmr_pkg::MODE_READ;
    else if (p < 90) r.mode = mrpmr_pkg::MODE_COMPACT;
    else r.mode = mrpmr_pkg::MODE_STATUS;
    r.mtype = mrpmr_pkg::msg_type_e'($urandom_range(0, 3));
    r.src = ($urandom_range(0, 3) == 0) ? sb.sens_id[7:0] : 8'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (p < 40) r.tgt = 8'($urandom_range(0, N_HEADS - 1));
    else if (p < 55) r.tgt = mrpmr_pkg::BROADCAST_ID;
    else if (p < 70) r.tgt = sb.prot_id[7:0];
    else r.tgt = 8'($urandom_range(0, 255));
    r.addr = $urandom;
    r.len = $urandom;
    r.reader = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                            8'($urandom_range(0, N_HEADS - 1));
    r.maxc = 6'($urandom_range(0, 63));
    return r;
  endfunction

  initial begin
    int unsigned n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: filter, extremes, every mode, out-of-range reader
    send(mk(mrpmr_pkg::MODE_STATUS, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 0));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 63));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_ORDINARY, 5, 0, 32'h1234, 32'h5, 0, 0));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_ORDINARY, 1, 0, 32'h0, 32'hFFFF_FFFF, 0, 0));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_OTHER, 0, 0, 32'hFFFF_FFFF, 32'h0, 0, 0));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_NOTICE, 255, 3, 32'hA5A5_5A5A,
            32'h5A5A_A5A5, 0, 0));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_OTHER, 255, mrpmr_pkg::BROADCAST_ID,
            32'h1, 32'h2, 0, 0));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_ORDINARY, 7, 15, 32'h3, 32'h4, 0, 0));
    send(mk(mrpmr_pkg::MODE_STATUS, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 0));
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_ALERT, 2, mrpmr_pkg::BROADCAST_ID,
            32'hFFFF_FFFF, 0, 0, 0));
    send(mk(mrpmr_pkg::MODE_STATUS, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 0));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 3, 0));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 3, 1));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 63));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 16, 63));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 255, 63));
    send(mk(mrpmr_pkg::MODE_READ, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 15, 63));
    send(mk(mrpmr_pkg::MODE_COMPACT, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 0));
    send(mk(mrpmr_pkg::MODE_STATUS, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 0));
    drain();

    write_reg(mrpmr_pkg::REG_PROTECTED, 8'd254);
    write_reg(mrpmr_pkg::REG_SENSORY, 8'd0);
    for (n = 0; n < 110; n++) send(rand_request());

    // hold the output off while requests keep coming, so the input backs up
    hold_left = 400;
    for (n = 0; n < 40; n++) send(rand_request());
    drain();

    write_reg(mrpmr_pkg::REG_PROTECTED, 8'd7);
    write_reg(mrpmr_pkg::REG_SENSORY, 8'd254);
    send_idle_pct = 80;
    recv_idle_pct = 36;
    send(mk(mrpmr_pkg::MODE_PUSH, mrpmr_pkg::MSG_ALERT, 9, 7, $urandom, $urandom, 0, 0));
    send(mk(mrpmr_pkg::MODE_STATUS, mrpmr_pkg::MSG_ORDINARY, 0, 0, 0, 0, 0, 0));
    for (n = 0; n < 80; n++) send(rand_request());
    drain();

    write_reg(mrpmr_pkg::REG_PROTECTED, 8'd0);
    write_reg(mrpmr_pkg::REG_SENSORY, 8'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (n = 0; n < 80; n++) send(rand_request());
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("multi_reader_priority_message_ring_top test passed");
    end else begin
      $display("multi_reader_priority_message_ring_top test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
